>>> rtl/vcs_pkg.sv
// ----------------------------------------------------------------------------
// vcs_pkg
// Shared types and constants for the vertex cache simulator.
// ----------------------------------------------------------------------------
package vcs_pkg;

	localparam int VERTEX_BITS     = 32;  // width of the vertex index field
	localparam int COUNT_BITS      = 32;  // width of the running counters
	localparam int POS_BITS        = 5;   // width of the reported position
	localparam int MAX_POS_BITS    = 6;   // slot number width at the deepest cache
	localparam int OUT_DATA_BITS   = 72;  // 70 bits of result fields, byte padded
	localparam int DEF_CACHE_DEPTH = 32;
	localparam int DEF_INDEX_BITS  = 32;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	typedef enum logic {
		CMD_ACCESS = 1'b0,
		CMD_CLEAR  = 1'b1
	} cmd_t;

	// outcome of one lookup
	typedef struct packed {
		logic                    hit;
		logic [MAX_POS_BITS-1:0] pos;
	} lookup_t;

	// list update requested for the current transaction
	typedef struct packed {
		logic clear;     // empty every slot
		logic fill;      // miss: shift everything, insert at the front
		logic lru_move;  // hit in lru mode: move the hit slot to the front
	} update_t;

endpackage

>>> rtl/vertex_cache_simulator.sv
// ----------------------------------------------------------------------------
// vertex_cache_simulator
// Post-transform vertex cache model with hit position and saturating counts.
// ----------------------------------------------------------------------------
// Takes one transaction per clock unless the output stalls, and returns one
// result per transaction via the input and result registers. Each access is
// looked up in all slots at once and the list is updated in the same cycle,
// so throughput is set by that single compare-and-shift step between the
// input register and the result register. tuser carries the command (access
// or clear); a clear empties the list and zeroes both counters. The
// update_on_hit register selects lru (1) or fifo (0) behaviour on a hit and
// should only be written while no transaction is in flight.
module vertex_cache_simulator import vcs_pkg::*; #(
	parameter int CACHE_DEPTH = DEF_CACHE_DEPTH,
	parameter int INDEX_BITS  = DEF_INDEX_BITS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_wen,
	input  logic                     cfg_wdata,     // update_on_hit
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [VERTEX_BITS-1:0]   s_tdata,       // vertex_index
	input  logic                     s_tuser,       // command
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [OUT_DATA_BITS-1:0] m_tdata        // hit, position, miss_count,
	                                                // access_count, 2 bits zero
);

	logic                   update_on_hit_q;

	logic                   valid_s1;
	cmd_t                   cmd_s1;
	logic [INDEX_BITS-1:0]  index_s1;

	logic                   valid_s2;
	logic                   hit_s2;
	logic [POS_BITS-1:0]    pos_s2;
	logic [COUNT_BITS-1:0]  misses_s2;
	logic [COUNT_BITS-1:0]  accesses_s2;

	logic [COUNT_BITS-1:0]  misses_q;
	logic [COUNT_BITS-1:0]  accesses_q;

	logic                   advance;
	logic                   is_access;
	logic                   hit;
	logic [COUNT_BITS-1:0]  misses_next;
	logic [COUNT_BITS-1:0]  accesses_next;

	logic [INDEX_BITS-1:0]  entry_index [CACHE_DEPTH];
	logic [CACHE_DEPTH-1:0] entry_valid;
	lookup_t                lookup;
	update_t                upd;

	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			update_on_hit_q <= 1'b0;
		end else if (cfg_wen) begin
			update_on_hit_q <= cfg_wdata;
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1   <= cmd_t'(s_tuser);
			index_s1 <= s_tdata[INDEX_BITS-1:0];
		end
	end

	vcs_match #(
		.CACHE_DEPTH(CACHE_DEPTH),
		.INDEX_BITS (INDEX_BITS)
	) u_match (
		.entry_index(entry_index),
		.entry_valid(entry_valid),
		.key        (index_s1),
		.result     (lookup)
	);

	assign is_access    = (cmd_s1 == CMD_ACCESS);
	assign hit          = is_access && lookup.hit;
	assign upd.clear    = advance && !is_access;
	assign upd.fill     = advance && is_access && !lookup.hit;
	assign upd.lru_move = advance && is_access && lookup.hit && update_on_hit_q;

	vcs_entries #(
		.CACHE_DEPTH(CACHE_DEPTH),
		.INDEX_BITS (INDEX_BITS)
	) u_entries (
		.clk        (clk),
		.arst_n     (arst_n),
		.upd        (upd),
		.lookup     (lookup),
		.key        (index_s1),
		.entry_index(entry_index),
		.entry_valid(entry_valid)
	);

	// saturating counters
	always_comb begin
		misses_next   = misses_q;
		accesses_next = accesses_q;
		if (!is_access) begin
			misses_next   = '0;
			accesses_next = '0;
		end else begin
			if (accesses_q != COUNT_MAX) begin
				accesses_next = accesses_q + COUNT_BITS'(1);
			end
			if (!lookup.hit && (misses_q != COUNT_MAX)) begin
				misses_next = misses_q + COUNT_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			misses_q   <= '0;
			accesses_q <= '0;
			valid_s2   <= 1'b0;
		end else begin
			if (advance) begin
				misses_q   <= misses_next;
				accesses_q <= accesses_next;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// result stage
	always_ff @(posedge clk) begin
		if (advance) begin
			hit_s2      <= hit;
			pos_s2      <= hit ? lookup.pos[POS_BITS-1:0] : '0;
			misses_s2   <= misses_next;
			accesses_s2 <= accesses_next;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {2'b00, accesses_s2, misses_s2, pos_s2, hit_s2};

	// clear leaves no valid slot behind
	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		upd.clear |=> (entry_valid == '0))
		else $error("slots still valid after clear");

	// misses never run ahead of accesses
	a_miss_le_access: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (misses_s2 <= accesses_s2))
		else $error("miss count above access count");

	// a miss or clear reports slot zero
	a_miss_pos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !hit_s2) |-> (pos_s2 == '0))
		else $error("non-zero position without a hit");

	// a stalled input stage keeps its transaction
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(index_s1) && $stable(cmd_s1)))
		else $error("input stage lost a transaction");

endmodule

>>> rtl/vcs_match.sv
// ----------------------------------------------------------------------------
// vcs_match
// Parallel compare of a key with every valid slot, newest match wins.
// ----------------------------------------------------------------------------
module vcs_match import vcs_pkg::*; #(
	parameter int CACHE_DEPTH = DEF_CACHE_DEPTH,
	parameter int INDEX_BITS  = DEF_INDEX_BITS
) (
	input  logic [INDEX_BITS-1:0]  entry_index [CACHE_DEPTH],
	input  logic [CACHE_DEPTH-1:0] entry_valid,
	input  logic [INDEX_BITS-1:0]  key,
	output lookup_t                result
);

	// scan from the oldest slot down so the lowest matching slot is kept
	always_comb begin
		result = '0;
		for (int i = CACHE_DEPTH - 1; i >= 0; i--) begin
			if (entry_valid[i] && (entry_index[i] == key)) begin
				result.hit = 1'b1;
				result.pos = MAX_POS_BITS'(i);
			end
		end
	end

endmodule

>>> rtl/vcs_entries.sv
// ----------------------------------------------------------------------------
// vcs_entries
// Ordered slot list, newest at slot 0, with shift-in and move-to-front.
// ----------------------------------------------------------------------------
module vcs_entries import vcs_pkg::*; #(
	parameter int CACHE_DEPTH = DEF_CACHE_DEPTH,
	parameter int INDEX_BITS  = DEF_INDEX_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  update_t                upd,
	input  lookup_t                lookup,
	input  logic [INDEX_BITS-1:0]  key,
	output logic [INDEX_BITS-1:0]  entry_index [CACHE_DEPTH],
	output logic [CACHE_DEPTH-1:0] entry_valid
);

	logic [CACHE_DEPTH-1:0] shift_en;
	logic                   write_front;

	assign write_front = upd.fill || upd.lru_move;

	// a slot takes its newer neighbour on a miss, or up to the hit slot on a move
	always_comb begin
		for (int i = 0; i < CACHE_DEPTH; i++) begin
			shift_en[i] = upd.fill || (upd.lru_move && (MAX_POS_BITS'(i) <= lookup.pos));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_valid <= '0;
		end else if (upd.clear) begin
			entry_valid <= '0;
		end else if (write_front) begin
			for (int i = 1; i < CACHE_DEPTH; i++) begin
				if (shift_en[i]) begin
					entry_valid[i] <= entry_valid[i-1];
				end
			end
			entry_valid[0] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (write_front) begin
			for (int i = 1; i < CACHE_DEPTH; i++) begin
				if (shift_en[i]) begin
					entry_index[i] <= entry_index[i-1];
				end
			end
			entry_index[0] <= key;
		end
	end

endmodule
